// ===== sv/qte_pkg.sv =====
`timescale 1ns / 1ps
package qte_pkg;

    // Iteration count of each angle CORDIC (8 to 24)
    localparam int CORDIC_STEPS = 16;

    // Datapath widths
    localparam int W_Q    = 16;   // quaternion component, Q14
    localparam int W_P    = 32;   // product of two components, Q28
    localparam int W_S    = 34;   // doubled sum of two products, Q28
    localparam int W_V    = 37;   // CORDIC vector lane, grows by the CORDIC gain
    localparam int W_Z    = 28;   // CORDIC angle accumulator, Q24 radians
    localparam int W_R    = 57;   // square root radicand, up to 2^56
    localparam int W_ROOT = 29;   // square root result, up to 2^28
    localparam int W_A    = 16;   // angle result, Q13 radians
    localparam int W_PA   = 15;   // pitch angle result

    // Square root works two radicand bits per stage
    localparam int SQ_STEPS   = (W_R + 1) / 2;
    localparam int FRONT_LAT  = 4;
    localparam int CORDIC_LAT = CORDIC_STEPS + 2;
    localparam int DEPTH      = FRONT_LAT + SQ_STEPS + CORDIC_LAT;

    localparam logic signed [W_S-1:0] ONE_Q28     = W_S'(64'sd268435456);
    localparam logic signed [W_Z-1:0] HALF_PI_Q24 = W_Z'(64'sd26353589);
    localparam logic signed [W_A-1:0] PI_Q13      = 16'sd25736;
    localparam logic signed [W_A-1:0] HALF_PI_Q13 = 16'sd12868;

    // Sine and cosine terms of the three angles
    typedef struct packed {
        logic signed [W_S-1:0] sr;
        logic signed [W_S-1:0] cr;
        logic signed [W_S-1:0] sp;
        logic signed [W_S-1:0] sy;
        logic signed [W_S-1:0] cy;
        logic                  clamp;
    } t_side;

    // Pitch saturation flags
    typedef struct packed {
        logic clamp;
        logic neg;
    } t_pflag;

    // Elementary angles atan(2^-i) in Q24
    function automatic logic signed [W_Z-1:0] atan_q24(input int i);
        logic signed [W_Z-1:0] v;
        case (i)
            0:       v = W_Z'(64'sd13176795);
            1:       v = W_Z'(64'sd7778716);
            2:       v = W_Z'(64'sd4110060);
            3:       v = W_Z'(64'sd2086331);
            4:       v = W_Z'(64'sd1047214);
            5:       v = W_Z'(64'sd524117);
            6:       v = W_Z'(64'sd262123);
            7:       v = W_Z'(64'sd131069);
            8:       v = W_Z'(64'sd65536);
            9:       v = W_Z'(64'sd32768);
            10:      v = W_Z'(64'sd16384);
            11:      v = W_Z'(64'sd8192);
            12:      v = W_Z'(64'sd4096);
            13:      v = W_Z'(64'sd2048);
            14:      v = W_Z'(64'sd1024);
            15:      v = W_Z'(64'sd512);
            16:      v = W_Z'(64'sd256);
            17:      v = W_Z'(64'sd128);
            18:      v = W_Z'(64'sd64);
            19:      v = W_Z'(64'sd32);
            20:      v = W_Z'(64'sd16);
            21:      v = W_Z'(64'sd8);
            22:      v = W_Z'(64'sd4);
            23:      v = W_Z'(64'sd2);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/qte_front.sv =====
`timescale 1ns / 1ps
module qte_front import qte_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [W_Q-1:0] i_w,
    input  logic signed [W_Q-1:0] i_x,
    input  logic signed [W_Q-1:0] i_y,
    input  logic signed [W_Q-1:0] i_z,
    output t_side                 o_side,
    output logic [W_R-1:0]        o_rem
);

    logic signed [W_P-1:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    t_side                 r_side2, r_side3, r_side4, n_side2, n_side3;
    logic signed [57:0]    n_sq;
    logic [W_R-1:0]        r_sq, r_rem;

    // Stage 1: the component products that the sums need
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx <= i_w * i_x;
            r_yz <= i_y * i_z;
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_wy <= i_w * i_y;
            r_zx <= i_z * i_x;
            r_wz <= i_w * i_z;
            r_xy <= i_x * i_y;
            r_zz <= i_z * i_z;
        end
    end

    // Stage 2: doubled sums, Q28
    always_comb begin
        n_side2.sr    = (W_S'(r_wx) + W_S'(r_yz)) <<< 1;
        n_side2.cr    = ONE_Q28 - ((W_S'(r_xx) + W_S'(r_yy)) <<< 1);
        n_side2.sp    = (W_S'(r_wy) - W_S'(r_zx)) <<< 1;
        n_side2.sy    = (W_S'(r_wz) + W_S'(r_xy)) <<< 1;
        n_side2.cy    = ONE_Q28 - ((W_S'(r_yy) + W_S'(r_zz)) <<< 1);
        n_side2.clamp = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side2 <= n_side2;
        end
    end

    // Stage 3: square the sine term, flag a term at or beyond one
    assign n_sq = $signed(r_side2.sp[28:0]) * $signed(r_side2.sp[28:0]);

    always_comb begin
        n_side3       = r_side2;
        n_side3.clamp = (r_side2.sp >= ONE_Q28) || (r_side2.sp <= -ONE_Q28);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq    <= n_sq[W_R-1:0];
            r_side3 <= n_side3;
        end
    end

    // Stage 4: radicand of the cosine term
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem   <= (W_R'(1) << 56) - r_sq;
            r_side4 <= r_side3;
        end
    end

    assign o_side = r_side4;
    assign o_rem  = r_rem;

endmodule

// ===== sv/qte_isqrt.sv =====
`timescale 1ns / 1ps
module qte_isqrt import qte_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [W_R-1:0]    i_rem,
    input  t_side             i_side,
    output logic [W_ROOT-1:0] o_root,
    output t_side             o_side
);

    logic [W_R-1:0] r_rem [SQ_STEPS];
    logic [W_R-1:0] r_res [SQ_STEPS];
    t_side          r_side [SQ_STEPS];

    // One result bit per stage, most significant first
    genvar k;
    for (k = 0; k < SQ_STEPS; k++) begin : g_st
        localparam logic [W_R-1:0] BIT = W_R'(1) << (2 * (SQ_STEPS - 1 - k));
        logic [W_R-1:0] a_rem, a_res, trial, n_rem, n_res;
        t_side          a_side;

        if (k == 0) begin : g_in
            assign a_rem  = i_rem;
            assign a_res  = '0;
            assign a_side = i_side;
        end else begin : g_ch
            assign a_rem  = r_rem[k-1];
            assign a_res  = r_res[k-1];
            assign a_side = r_side[k-1];
        end

        assign trial = a_res + BIT;

        always_comb begin
            if (a_rem >= trial) begin
                n_rem = a_rem - trial;
                n_res = (a_res >> 1) + BIT;
            end else begin
                n_rem = a_rem;
                n_res = a_res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_res[k]  <= n_res;
                r_side[k] <= a_side;
            end
        end
    end

    assign o_root = r_res[SQ_STEPS-1][W_ROOT-1:0];
    assign o_side = r_side[SQ_STEPS-1];

endmodule

// ===== sv/qte_cordic.sv =====
`timescale 1ns / 1ps
module qte_cordic import qte_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [W_V-1:0] i_y,
    input  logic signed [W_V-1:0] i_x,
    input  logic                  i_half_range,
    output logic signed [W_A-1:0] o_angle
);

    logic signed [W_V-1:0] r_x [CORDIC_STEPS+1];
    logic signed [W_V-1:0] r_y [CORDIC_STEPS+1];
    logic signed [W_Z-1:0] r_z [CORDIC_STEPS+1];
    logic                  r_zero [CORDIC_STEPS+1];
    logic signed [W_A-1:0] r_angle;

    logic signed [W_V-1:0] n_x0, n_y0;
    logic signed [W_Z-1:0] n_z0, zsum, zq, lim;

    // Fold a vector in the left half plane by a quarter turn
    always_comb begin
        n_x0 = i_x;
        n_y0 = i_y;
        n_z0 = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x0 = i_y;
                n_y0 = -i_x;
                n_z0 = HALF_PI_Q24;
            end else begin
                n_x0 = -i_y;
                n_y0 = i_x;
                n_z0 = -HALF_PI_Q24;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_zero[0] <= (i_x == 0) && (i_y == 0);
        end
    end

    // Vectoring steps: drive y toward zero
    genvar i;
    for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [W_V-1:0] dx, dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + atan_q24(i);
                end else begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - atan_q24(i);
                end
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    // Round to Q13 and saturate
    assign zsum = r_z[CORDIC_STEPS] + W_Z'(1024);
    assign zq   = zsum >>> 11;
    assign lim  = i_half_range ? W_Z'(HALF_PI_Q13) : W_Z'(PI_Q13);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[CORDIC_STEPS]) begin
                r_angle <= '0;
            end else if (zq > lim) begin
                r_angle <= W_A'(lim);
            end else if (zq < -lim) begin
                r_angle <= W_A'(-lim);
            end else begin
                r_angle <= W_A'(zq);
            end
        end
    end

    assign o_angle = r_angle;

endmodule

// ===== sv/quaternion_to_euler_angles_top.sv =====
// Converts a unit quaternion (real, i, j, k in signed Q14) into roll, pitch
// and yaw in signed Q13 radians. The block is a fully pipelined datapath: it
// takes one quaternion every cycle while o_ready is high, and each result
// passes through qte_pkg::DEPTH stages (with 16 CORDIC steps: 4 product and sum
// stages, 29 square root stages for the pitch cosine term, and 18 CORDIC
// stages). When o_ready is low the whole pipeline holds; a result waits in
// the last stage until taken. A pitch sine term of magnitude one or more
// gives pitch of plus or minus pi/2 and raises o_pitch_clamped.
`timescale 1ns / 1ps
module quaternion_to_euler_angles_top import qte_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [W_Q-1:0]  i_quat_real,
    input  logic signed [W_Q-1:0]  i_quat_i,
    input  logic signed [W_Q-1:0]  i_quat_j,
    input  logic signed [W_Q-1:0]  i_quat_k,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [W_A-1:0]  o_roll_angle,
    output logic signed [W_PA-1:0] o_pitch_angle,
    output logic signed [W_A-1:0]  o_yaw_angle,
    output logic                   o_pitch_clamped
);

    logic                  en;
    logic [DEPTH-1:0]      r_v;
    t_pflag                r_pf [CORDIC_LAT];
    t_side                 front_side, sq_side;
    logic [W_R-1:0]        front_rem;
    logic [W_ROOT-1:0]     root;
    logic signed [W_A-1:0] roll, pitch, yaw;

    // Advance whenever the last stage is empty or being taken
    assign en      = !r_v[DEPTH-1] || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[DEPTH-2:0], i_valid};
        end
    end

    qte_front u_front (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_w    (i_quat_real),
        .i_x    (i_quat_i),
        .i_y    (i_quat_j),
        .i_z    (i_quat_k),
        .o_side (front_side),
        .o_rem  (front_rem)
    );

    qte_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rem  (front_rem),
        .i_side (front_side),
        .o_root (root),
        .o_side (sq_side)
    );

    qte_cordic u_roll (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_y          (W_V'(sq_side.sr)),
        .i_x          (W_V'(sq_side.cr)),
        .i_half_range (1'b0),
        .o_angle      (roll)
    );

    qte_cordic u_pitch (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_y          (W_V'(sq_side.sp)),
        .i_x          (W_V'({1'b0, root})),
        .i_half_range (1'b1),
        .o_angle      (pitch)
    );

    qte_cordic u_yaw (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_y          (W_V'(sq_side.sy)),
        .i_x          (W_V'(sq_side.cy)),
        .i_half_range (1'b0),
        .o_angle      (yaw)
    );

    // Carry the pitch clamp flags alongside the CORDIC stages
    genvar p;
    for (p = 0; p < CORDIC_LAT; p++) begin : g_pf
        if (p == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_pf[p].clamp <= sq_side.clamp;
                    r_pf[p].neg   <= sq_side.sp[W_S-1];
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_pf[p] <= r_pf[p-1];
                end
            end
        end
    end

    assign o_valid         = r_v[DEPTH-1];
    assign o_roll_angle    = roll;
    assign o_yaw_angle     = yaw;
    assign o_pitch_clamped = r_pf[CORDIC_LAT-1].clamp;

    // Replace pitch by a quarter turn when the sine term saturated
    always_comb begin
        if (r_pf[CORDIC_LAT-1].clamp) begin
            o_pitch_angle = r_pf[CORDIC_LAT-1].neg ? W_PA'(-HALF_PI_Q13)
                                                   : W_PA'(HALF_PI_Q13);
        end else begin
            o_pitch_angle = pitch[W_PA-1:0];
        end
    end

endmodule

// ===== sv/qte_checker.sv =====
`timescale 1ns / 1ps
module qte_checker import qte_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_ready,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic signed [W_A-1:0]  o_roll_angle,
    input logic signed [W_PA-1:0] o_pitch_angle,
    input logic signed [W_A-1:0]  o_yaw_angle,
    input logic                   o_pitch_clamped
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_roll_angle)
            && $stable(o_pitch_angle) && $stable(o_yaw_angle)
            && $stable(o_pitch_clamped))
        else $error("stalled result changed");

    // Input side stalls only behind a waiting result
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input stalled without a waiting result");

    // Clamped pitch is a quarter turn
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pitch_clamped |->
            (o_pitch_angle == 15'sd12868) || (o_pitch_angle == -15'sd12868))
        else $error("clamped pitch not at a quarter turn");

    // Angles stay within their ranges
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roll_angle <= 16'sd25736) && (o_roll_angle >= -16'sd25736)
            && (o_yaw_angle <= 16'sd25736) && (o_yaw_angle >= -16'sd25736)
            && (o_pitch_angle <= 15'sd12868) && (o_pitch_angle >= -15'sd12868))
        else $error("angle out of range");

endmodule

bind quaternion_to_euler_angles_top qte_checker u_qte_checker (.*);
